// ===== rtl/sckx_pkg.sv =====
package sckx_pkg;

  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 64;
  localparam int DataW     = 8;
  localparam int CounterW  = 32;
  localparam int PosW      = 5;
  localparam int RoundW    = 6;
  localparam int NumRounds = 64;
  localparam logic [31:0] MsgBits = 32'd416;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY0   = 3'd0,
    CFG_KEY1   = 3'd1,
    CFG_KEY2   = 3'd2,
    CFG_KEY3   = 3'd3,
    CFG_NONCE0 = 3'd4,
    CFG_NONCE1 = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_FINISH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic hash_start;
    logic hash_step;
    logic hash_finish;
    logic take_byte;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_block;
    logic round_last;
  } ctrl_stat_t;

  function automatic logic [31:0] round_k(input logic [RoundW-1:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

endpackage

// ===== rtl/sckx_byte_if.sv =====
interface sckx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  logic       last;

  modport source (output valid, output data, output last, input ready);
  modport sink (input valid, input data, input last, output ready);
endinterface

// ===== rtl/sha256_counter_keystream_xor.sv =====
// Channel | Direction | Payload
// in      | sink      | data (8), last (1)
// out     | source    | data (8), last (1)
// cfg     | write     | index (3), data (64)
// A byte at block position 1..31 is transferred in, then its result is on out
// from the next cycle until it transfers.
// A byte at position 0 first waits for the 64-round SHA-256 unit.
// One byte is in flight at a time; a stalled output holds the next byte off.
// rst_n is synchronous; counter and position return to zero.
module sha256_counter_keystream_xor (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sckx_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [sckx_pkg::CfgDataW-1:0]   cfg_data,
  sckx_byte_if.sink                       in_ch,
  sckx_byte_if.source                     out_ch
);
  import sckx_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  sckx_datapath u_dp (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_data(in_ch.data), .in_last(in_ch.last),
    .out_data(out_ch.data), .out_last(out_ch.last),
    .cmd, .stat
  );

  sckx_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat, .cmd
  );
endmodule

// ===== rtl/sckx_ctrl.sv =====
module sckx_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  sckx_pkg::ctrl_stat_t stat,
  output sckx_pkg::ctrl_cmd_t  cmd
);
  import sckx_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (stat.need_block) begin
            cmd.hash_start = 1'b1;
            state_nxt      = ST_HASH;
          end else begin
            in_ready       = 1'b1;
            cmd.take_byte  = 1'b1;
            state_nxt      = ST_OUT;
          end
        end
      end
      ST_HASH: begin
        cmd.hash_step = 1'b1;
        if (stat.round_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.hash_finish = 1'b1;
        state_nxt       = ST_IDLE;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_out_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_byte |=> out_valid) else $error("no result after byte taken");
  a_no_take_on_boundary: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !stat.need_block) else $error("byte taken without fresh block");
  a_finish_after_hash: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.hash_finish |-> $past(cmd.hash_step)) else $error("finish out of order");
endmodule

// ===== rtl/sckx_datapath.sv =====
module sckx_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [sckx_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [sckx_pkg::CfgDataW-1:0]        cfg_data,
  input  logic [sckx_pkg::DataW-1:0]           in_data,
  input  logic                                 in_last,
  output logic [sckx_pkg::DataW-1:0]           out_data,
  output logic                                 out_last,
  input  sckx_pkg::ctrl_cmd_t                  cmd,
  output sckx_pkg::ctrl_stat_t                 stat
);
  import sckx_pkg::*;

  logic [63:0] key_r [4];
  logic [63:0] nonce_r [2];
  logic [255:0] ks_r;
  logic [CounterW-1:0] counter_r;
  logic [PosW-1:0] pos_r;
  logic [RoundW-1:0] round_r;
  logic [31:0] w_r [16];
  logic [31:0] s_r [8];
  logic [DataW-1:0] out_data_r;
  logic out_last_r;
  logic fresh_r;

  logic [31:0] w_init [16];
  logic [31:0] a, e, t1, t2, s0, s1, wn;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      w_init[2*i]   = key_r[i][63:32];
      w_init[2*i+1] = key_r[i][31:0];
    end
    for (int i = 0; i < 2; i++) begin
      w_init[8+2*i] = nonce_r[i][63:32];
      w_init[9+2*i] = nonce_r[i][31:0];
    end
    w_init[12] = counter_r;
    w_init[13] = 32'h8000_0000;
    w_init[14] = 32'h0;
    w_init[15] = MsgBits;
  end

  always_comb begin
    a  = s_r[0];
    e  = s_r[4];
    t1 = s_r[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
       + ((e & s_r[5]) ^ (~e & s_r[6])) + round_k(round_r) + w_r[0];
    t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
       + ((a & s_r[1]) ^ (a & s_r[2]) ^ (s_r[1] & s_r[2]));
    s0 = {w_r[1][6:0], w_r[1][31:7]} ^ {w_r[1][17:0], w_r[1][31:18]} ^ (w_r[1] >> 3);
    s1 = {w_r[14][16:0], w_r[14][31:17]} ^ {w_r[14][18:0], w_r[14][31:19]}
       ^ (w_r[14] >> 10);
    wn = w_r[0] + s0 + w_r[9] + s1;
  end

  assign stat.need_block = (pos_r == '0) && !fresh_r;
  assign stat.round_last = (round_r == RoundW'(NumRounds - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
      for (int i = 0; i < 2; i++) nonce_r[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_KEY0:   key_r[0]   <= cfg_data;
        CFG_KEY1:   key_r[1]   <= cfg_data;
        CFG_KEY2:   key_r[2]   <= cfg_data;
        CFG_KEY3:   key_r[3]   <= cfg_data;
        CFG_NONCE0: nonce_r[0] <= cfg_data;
        CFG_NONCE1: nonce_r[1] <= cfg_data;
        default: ;
      endcase
    end
  end

  // The schedule is a 16-word shift line: word 0 feeds the current round.
  always_ff @(posedge clk) begin
    if (cmd.hash_start) begin
      w_r <= w_init;
      for (int i = 0; i < 8; i++) s_r[i] <= init_h(3'(i));
      round_r <= '0;
    end else if (cmd.hash_step) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wn;
      s_r[7] <= s_r[6];
      s_r[6] <= s_r[5];
      s_r[5] <= e;
      s_r[4] <= s_r[3] + t1;
      s_r[3] <= s_r[2];
      s_r[2] <= s_r[1];
      s_r[1] <= a;
      s_r[0] <= t1 + t2;
      round_r <= round_r + 1'b1;
    end
    if (cmd.hash_finish) begin
      for (int i = 0; i < 8; i++) ks_r[255-32*i -: 32] <= init_h(3'(i)) + s_r[i];
    end
  end

  // A fresh block is formed at position 0, so the next byte there stays at
  // position 0 until the hash is finished; a marker bit avoids re-hashing.
  logic [7:0] ks_byte;
  assign ks_byte = ks_r[255 - 8*pos_r -: 8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_r <= '0;
      pos_r     <= '0;
      fresh_r   <= 1'b0;
    end else begin
      if (cmd.hash_finish) fresh_r <= 1'b1;
      if (cmd.take_byte) begin
        fresh_r <= 1'b0;
        if (in_last) begin
          pos_r     <= '0;
          counter_r <= '0;
        end else begin
          pos_r <= pos_r + 1'b1;
          if (pos_r == '1) counter_r <= counter_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      out_data_r <= in_data ^ ks_byte;
      out_last_r <= in_last;
    end
  end

  assign out_data = out_data_r;
  assign out_last = out_last_r;

  a_hash_at_boundary: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.hash_start |-> pos_r == '0) else $error("hash started mid-block");
  a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_byte && !in_last |=> pos_r == $past(pos_r) + 1'b1)
    else $error("byte position did not advance");
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_byte && in_last |=> pos_r == '0 && counter_r == '0)
    else $error("last byte did not clear counters");
endmodule
